// ===== hw/rtl/tank_fill_and_irrigation_sequencer_core_macros.svh =====
// Assertion helpers for the tank fill and irrigation sequencer.
// Each macro takes a label, clock, reset, condition pair and a message.
`ifndef TANK_FILL_AND_IRRIGATION_SEQUENCER_CORE_MACROS_SVH
`define TANK_FILL_AND_IRRIGATION_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication
`define TFIS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define TFIS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tfis_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfis_pkg
// Shared types and codes of the tank fill and irrigation sequencer.
// ----------------------------------------------------------------------------
package tfis_pkg;

   // Mode codes, also reported on the result channel
   localparam logic [2:0] MODE_IDLE  = 3'd0;
   localparam logic [2:0] MODE_FILL  = 3'd1;
   localparam logic [2:0] MODE_SEC1  = 3'd2;
   localparam logic [2:0] MODE_SEC2  = 3'd3;
   localparam logic [2:0] MODE_PAGE1 = 3'd4;
   localparam logic [2:0] MODE_PAGE2 = 3'd5;
   localparam logic [2:0] MODE_PAGE3 = 3'd6;

   // Configuration register indexes
   localparam logic [1:0] CSR_START_HOUR     = 2'd0;
   localparam logic [1:0] CSR_START_MINUTE   = 2'd1;
   localparam logic [1:0] CSR_SECTOR_SECONDS = 2'd2;
   localparam logic [1:0] CSR_WEEKDAY_MASK   = 2'd3;

   localparam int unsigned ItemBits   = 18;
   localparam int unsigned ResultBits = 7;

   // One input item, last member in the lowest bits
   typedef struct packed {
      logic [2:0] weekday_now;
      logic [5:0] minute_now;
      logic [4:0] hour_now;
      logic       return_key;
      logic       menu_key;
      logic       high_level;
      logic       low_level;
   } item_type;

   // One result item, last member in the lowest bits
   typedef struct packed {
      logic [2:0] mode_now;
      logic       sector_two_on;
      logic       sector_one_on;
      logic       tank_valve_on;
      logic       pump_on;
   } result_type;

   typedef struct packed {
      logic [4:0]  start_hour;
      logic [5:0]  start_minute;
      logic [15:0] sector_seconds;
      logic [6:0]  weekday_mask;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic        low_seen;
      logic        high_seen;
      logic        menu_seen;
      logic        return_seen;
      logic        irrigation_due;
      logic [15:0] run_counter;
   } state_type;

endpackage

// ===== hw/rtl/tfis_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfis_step
// One-tick update: latches events, advances the mode, drives the relays.
// ----------------------------------------------------------------------------
module tfis_step (
   input  tfis_pkg::state_type  cur,
   input  tfis_pkg::cfg_type    cfg,
   input  tfis_pkg::item_type   item,
   output tfis_pkg::state_type  nxt,
   output tfis_pkg::result_type res
);

   logic time_match;
   logic day_en;

   assign time_match = (item.hour_now == cfg.start_hour) &&
                       (item.minute_now == cfg.start_minute);

   // Weekday 1..7 selects mask bit 0..6; weekday 0 enables nothing
   always_comb begin
      logic [2:0] bit_idx;
      bit_idx = item.weekday_now - 3'd1;
      day_en  = (item.weekday_now != 3'd0) && cfg.weekday_mask[bit_idx];
   end

   // Mode logic
   always_comb begin
      nxt = cur;
      res = '0;
      nxt.low_seen    = cur.low_seen    | item.low_level;
      nxt.high_seen   = cur.high_seen   | item.high_level;
      nxt.menu_seen   = cur.menu_seen   | item.menu_key;
      nxt.return_seen = cur.return_seen | item.return_key;

      case (cur.mode)
         tfis_pkg::MODE_IDLE: begin
            // low level starts filling unless irrigation is pending
            if (nxt.low_seen && !cur.irrigation_due) nxt.mode = tfis_pkg::MODE_FILL;
            if (time_match) nxt.irrigation_due = 1'b1;
            if (nxt.irrigation_due && (nxt.mode != tfis_pkg::MODE_FILL) && day_en)
               nxt.mode = tfis_pkg::MODE_SEC1;
            // menu key wins over both
            if (nxt.menu_seen) begin
               nxt.menu_seen = 1'b0;
               nxt.mode      = tfis_pkg::MODE_PAGE1;
            end
         end
         tfis_pkg::MODE_FILL: begin
            if (time_match) nxt.irrigation_due = 1'b1;
            nxt.low_seen = 1'b0;
            if (nxt.high_seen) begin
               nxt.high_seen = 1'b0;
               nxt.mode      = tfis_pkg::MODE_IDLE;
            end else begin
               res.pump_on       = 1'b1;
               res.tank_valve_on = 1'b1;
            end
         end
         tfis_pkg::MODE_SEC1, tfis_pkg::MODE_SEC2: begin
            if (cur.run_counter >= cfg.sector_seconds) begin
               nxt.run_counter = '0;
               if (cur.mode == tfis_pkg::MODE_SEC1) begin
                  nxt.mode = tfis_pkg::MODE_SEC2;
               end else begin
                  nxt.mode           = tfis_pkg::MODE_IDLE;
                  nxt.irrigation_due = 1'b0;
               end
            end else begin
               res.pump_on       = 1'b1;
               res.sector_one_on = (cur.mode == tfis_pkg::MODE_SEC1);
               res.sector_two_on = (cur.mode == tfis_pkg::MODE_SEC2);
               nxt.run_counter   = cur.run_counter + 16'd1;
            end
         end
         tfis_pkg::MODE_PAGE1, tfis_pkg::MODE_PAGE2, tfis_pkg::MODE_PAGE3: begin
            // return wins and leaves the pages; menu steps on, page 3 to idle
            if (nxt.return_seen) begin
               nxt.return_seen = 1'b0;
               nxt.mode        = tfis_pkg::MODE_IDLE;
            end else if (nxt.menu_seen) begin
               nxt.menu_seen = 1'b0;
               nxt.mode = (cur.mode == tfis_pkg::MODE_PAGE3) ? tfis_pkg::MODE_IDLE
                                                             : cur.mode + 3'd1;
            end
         end
         default: begin
            nxt.mode = tfis_pkg::MODE_IDLE;
         end
      endcase

      res.mode_now = nxt.mode;
   end

endmodule

// ===== hw/rtl/tank_fill_and_irrigation_sequencer_core.sv =====
`timescale 1ns / 1ps
// Data path: an accepted item waits in the input register, and its result is
// moved to the result register, which drives rsp_tvalid, when it is empty or read.
// Throughput: one item per cycle; the input register and the result register
// each hold one item, so rsp back-pressure stalls req only when both are full.
// The tick update is a single combinational pass between those registers.
// Reset (synchronous, active high) empties both registers, clears the mode
// and event latches, and loads the configuration defaults.
// ----------------------------------------------------------------------------
// tank_fill_and_irrigation_sequencer_core
// Sequencer for tank filling and two irrigation sectors, one item per tick.
// ----------------------------------------------------------------------------
module tank_fill_and_irrigation_sequencer_core (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: low_level, high_level, menu_key, return_key, hour_now[5],
   //            minute_now[6], weekday_now[3], zero pad[6]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   // rsp_tdata: pump_on, tank_valve_on, sector_one_on, sector_two_on,
   //            mode_now[3], zero pad[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   logic                 in_vld_ff, in_vld_in;
   tfis_pkg::item_type   in_item_ff;
   logic                 rsp_vld_ff, rsp_vld_in;
   tfis_pkg::result_type rsp_data_ff;
   tfis_pkg::state_type  state_ff;
   tfis_pkg::state_type  state_in;
   tfis_pkg::cfg_type    cfg_ff;
   tfis_pkg::result_type step_res;
   logic                 advance;

   // Handshake
   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign in_vld_in  = (req_tvalid && req_tready) || (in_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && !rsp_tready);

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   // Tick update
   tfis_step u_step (
      .cur  (state_ff),
      .cfg  (cfg_ff),
      .item (in_item_ff),
      .nxt  (state_in),
      .res  (step_res)
   );

   // Pipeline control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         state_ff   <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (advance) state_ff <= state_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) in_item_ff <= req_tdata[tfis_pkg::ItemBits-1:0];
      if (advance) rsp_data_ff <= step_res;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_hour     <= 5'd10;
         cfg_ff.start_minute   <= 6'd31;
         cfg_ff.sector_seconds <= 16'd60;
         cfg_ff.weekday_mask   <= 7'd127;
      end else if (csr_we) begin
         case (csr_addr)
            tfis_pkg::CSR_START_HOUR:     cfg_ff.start_hour     <= csr_wdata[4:0];
            tfis_pkg::CSR_START_MINUTE:   cfg_ff.start_minute   <= csr_wdata[5:0];
            tfis_pkg::CSR_SECTOR_SECONDS: cfg_ff.sector_seconds <= csr_wdata;
            tfis_pkg::CSR_WEEKDAY_MASK:   cfg_ff.weekday_mask   <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

endmodule

// ===== hw/rtl/tfis_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfis_checker
// Port-level checks of the sequencer's result channel, bound to the top.
// ----------------------------------------------------------------------------
`include "tank_fill_and_irrigation_sequencer_core_macros.svh"

module tfis_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // Stalled result holds
   `TFIS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

   // Pump on means exactly one valve open; pump off means all closed
   `TFIS_ASSERT_SAME(a_pump_valve, clock, reset, rsp_tvalid, rsp_tdata[0] ? $onehot(rsp_tdata[3:1]) : (rsp_tdata[3:1] == 3'b000), "relay combination wrong")

   // Tank valve only while filling continues
   `TFIS_ASSERT_SAME(a_tank_mode, clock, reset, rsp_tvalid && rsp_tdata[1], rsp_tdata[6:4] == tfis_pkg::MODE_FILL, "tank valve outside filling")

   // A running sector stays in its own mode
   `TFIS_ASSERT_SAME(a_sector_mode, clock, reset, rsp_tvalid && (rsp_tdata[2] || rsp_tdata[3]), rsp_tdata[6:4] == (rsp_tdata[2] ? tfis_pkg::MODE_SEC1 : tfis_pkg::MODE_SEC2), "sector valve mode mismatch")

endmodule

bind tank_fill_and_irrigation_sequencer_core tfis_checker u_tfis_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the tank fill and irrigation sequencer core.
// A directed table walks filling, both sector runs, the config pages and the
// latched-key corner cases; random phases under several register settings
// follow. Each result is checked against its typed row or a model of the tick
// update kept in this file, with random idling and back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb;

   // Relay patterns, {sector_two, sector_one, tank_valve, pump}
   localparam logic [3:0] RLY_OFF  = 4'b0000;
   localparam logic [3:0] RLY_FILL = 4'b0011;
   localparam logic [3:0] RLY_SEC1 = 4'b0101;

   localparam int unsigned STALL_LIMIT = 3000;
   localparam int unsigned LONG_HOLD   = 300;
   localparam int unsigned HOLD_AT     = 600;
   localparam int unsigned NUM_PHASES  = 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // req_tdata: low_level, high_level, menu_key, return_key, hour_now[5],
   //            minute_now[6], weekday_now[3], zero pad[6]
   logic [23:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // rsp_tdata: pump_on, tank_valve_on, sector_one_on, sector_two_on,
   //            mode_now[3], zero pad[1]
   logic [7:0]  rsp_tdata;
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = '0;
   logic [15:0] csr_wdata  = '0;

   tank_fill_and_irrigation_sequencer_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // Sequencer model state, reset values
   tfis_pkg::cfg_type cfg   = '{5'd10, 6'd31, 16'd60, 7'h7F};
   logic [2:0]  tank_mode   = tfis_pkg::MODE_IDLE;
   logic        low_latch   = 1'b0;
   logic        high_latch  = 1'b0;
   logic        menu_latch  = 1'b0;
   logic        back_latch  = 1'b0;
   logic        water_due   = 1'b0;
   logic [15:0] run_ticks   = '0;

   tfis_pkg::result_type expected_drives[$];

   int unsigned err_cnt        = 0;
   int unsigned drives_seen    = 0;
   int unsigned quiet_cycles   = 0;
   int unsigned hold_left      = 0;
   bit          long_hold_done = 1'b0;
   int unsigned tx_burst       = 0;
   int unsigned rx_burst       = 0;

   // Directed table: one row per tick, expected drive typed only where obvious
   typedef struct packed {
      logic       lo;
      logic       hi;
      logic       mk;
      logic       rk;
      logic [4:0] hr;
      logic [5:0] mn;
      logic [2:0] wd;
      logic       typed;
      logic [3:0] relays;
      logic [2:0] mode;
   } step_row_type;

   // Run with start time 00:00, two-tick sectors, every weekday enabled
   step_row_type dir_table [26] = '{
      // idle after reset, then a short fill cycle
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd1,  6'd0,  3'd1, 1'b1, RLY_OFF,  tfis_pkg::MODE_IDLE},
      '{1'b1, 1'b0, 1'b0, 1'b0, 5'd1,  6'd0,  3'd1, 1'b1, RLY_OFF,  tfis_pkg::MODE_FILL},
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd1,  6'd0,  3'd1, 1'b1, RLY_FILL, tfis_pkg::MODE_FILL},
      '{1'b0, 1'b1, 1'b0, 1'b0, 5'd1,  6'd0,  3'd1, 1'b1, RLY_OFF,  tfis_pkg::MODE_IDLE},
      // time match starts sector one
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd0,  6'd0,  3'd1, 1'b1, RLY_OFF,  tfis_pkg::MODE_SEC1},
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd0,  6'd0,  3'd1, 1'b1, RLY_SEC1, tfis_pkg::MODE_SEC1},
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd1,  6'd0,  3'd2, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd1,  6'd0,  3'd3, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd1,  6'd0,  3'd3, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd1,  6'd0,  3'd3, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd1,  6'd0,  3'd3, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      // menu overrides a repeat trigger inside the start minute
      '{1'b0, 1'b0, 1'b1, 1'b0, 5'd0,  6'd0,  3'd1, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      '{1'b0, 1'b0, 1'b1, 1'b0, 5'd1,  6'd0,  3'd1, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      // return wins over menu; menu stays latched
      '{1'b0, 1'b0, 1'b1, 1'b1, 5'd1,  6'd0,  3'd1, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      // return latched in idle leaves page one at once
      '{1'b0, 1'b0, 1'b0, 1'b1, 5'd2,  6'd0,  3'd1, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd2,  6'd0,  3'd1, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      // weekday zero blocks the pending run, low level waits behind it
      '{1'b1, 1'b0, 1'b0, 1'b0, 5'd23, 6'd59, 3'd0, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd23, 6'd59, 3'd7, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      // high level latched during the run
      '{1'b0, 1'b1, 1'b0, 1'b0, 5'd23, 6'd59, 3'd7, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd23, 6'd59, 3'd7, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd23, 6'd59, 3'd7, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd23, 6'd59, 3'd7, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd23, 6'd59, 3'd7, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd23, 6'd59, 3'd7, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      // deferred fill, ended at once by the stale high level
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd23, 6'd59, 3'd7, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE},
      '{1'b0, 1'b0, 1'b0, 1'b0, 5'd23, 6'd59, 3'd7, 1'b0, RLY_OFF,  tfis_pkg::MODE_IDLE}
   };

   // Idle length: mostly short, a few long, sometimes a gapless burst
   function automatic int unsigned pick_gap(inout int unsigned burst);
      int unsigned r;
      if (burst != 0) begin
         burst = burst - 1;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         burst = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   // One tick of the sequencer: latch events, step the mode, drive relays
   task automatic advance_tick(input tfis_pkg::item_type it,
                               output tfis_pkg::result_type drive);
      logic [2:0] nxt;
      logic       at_start;
      logic       day_ok;
      drive    = '0;
      nxt      = tank_mode;
      at_start = (it.hour_now == cfg.start_hour) && (it.minute_now == cfg.start_minute);
      day_ok   = (it.weekday_now != 3'd0) ? cfg.weekday_mask[it.weekday_now - 3'd1] : 1'b0;
      low_latch  = low_latch  | it.low_level;
      high_latch = high_latch | it.high_level;
      menu_latch = menu_latch | it.menu_key;
      back_latch = back_latch | it.return_key;
      case (tank_mode)
         tfis_pkg::MODE_IDLE: begin
            if (low_latch && !water_due) nxt = tfis_pkg::MODE_FILL;
            if (at_start) water_due = 1'b1;
            if (water_due && nxt != tfis_pkg::MODE_FILL && day_ok) nxt = tfis_pkg::MODE_SEC1;
            if (menu_latch) begin
               menu_latch = 1'b0;
               nxt = tfis_pkg::MODE_PAGE1;
            end
         end
         tfis_pkg::MODE_FILL: begin
            if (at_start) water_due = 1'b1;
            low_latch = 1'b0;
            if (high_latch) begin
               high_latch = 1'b0;
               nxt = tfis_pkg::MODE_IDLE;
            end else begin
               drive.pump_on = 1'b1;
               drive.tank_valve_on = 1'b1;
            end
         end
         tfis_pkg::MODE_SEC1, tfis_pkg::MODE_SEC2: begin
            // >= so a lowered duration ends a run in progress
            if (run_ticks >= cfg.sector_seconds) begin
               run_ticks = '0;
               if (tank_mode == tfis_pkg::MODE_SEC1) begin
                  nxt = tfis_pkg::MODE_SEC2;
               end else begin
                  nxt = tfis_pkg::MODE_IDLE;
                  water_due = 1'b0;
               end
            end else begin
               drive.pump_on = 1'b1;
               if (tank_mode == tfis_pkg::MODE_SEC1) drive.sector_one_on = 1'b1;
               else drive.sector_two_on = 1'b1;
               run_ticks = run_ticks + 16'd1;
            end
         end
         tfis_pkg::MODE_PAGE1, tfis_pkg::MODE_PAGE2, tfis_pkg::MODE_PAGE3: begin
            if (back_latch) begin
               back_latch = 1'b0;
               nxt = tfis_pkg::MODE_IDLE;
            end else if (menu_latch) begin
               menu_latch = 1'b0;
               nxt = (tank_mode == tfis_pkg::MODE_PAGE3) ? tfis_pkg::MODE_IDLE
                                                         : tank_mode + 3'd1;
            end
         end
         default: nxt = tfis_pkg::MODE_IDLE;
      endcase
      tank_mode = nxt;
      drive.mode_now = nxt;
   endtask

   // Random tick, biased toward the programmed start time
   function automatic tfis_pkg::item_type rand_item();
      tfis_pkg::item_type it;
      it = '0;
      it.low_level  = ($urandom_range(0, 99) < 12);
      it.high_level = ($urandom_range(0, 99) < 12);
      it.menu_key   = ($urandom_range(0, 99) < 4);
      it.return_key = ($urandom_range(0, 99) < 5);
      if ($urandom_range(0, 99) < 30) begin
         it.hour_now   = cfg.start_hour;
         it.minute_now = cfg.start_minute;
      end else begin
         it.hour_now   = 5'($urandom_range(0, 23));
         it.minute_now = 6'($urandom_range(0, 59));
      end
      it.weekday_now = ($urandom_range(0, 99) < 4) ? 3'd0 : 3'($urandom_range(1, 7));
      return it;
   endfunction

   // Offer one item after a random gap; predict once it is taken
   task automatic push_item(input tfis_pkg::item_type it, input bit typed,
                            input tfis_pkg::result_type typed_drive);
      int unsigned          gap;
      tfis_pkg::result_type drive;
      gap = pick_gap(tx_burst);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, it};
      do @(posedge clock); while (!req_tready);
      advance_tick(it, drive);
      expected_drives.push_back(typed ? typed_drive : drive);
   endtask

   // Wait out every pending result with the request side idle
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all four registers on consecutive cycles
   task automatic program_regs(input logic [4:0] hr, input logic [5:0] mn,
                               input logic [15:0] secs, input logic [6:0] mask);
      csr_we    <= 1'b1;
      csr_addr  <= tfis_pkg::CSR_START_HOUR;
      csr_wdata <= {11'd0, hr};
      @(posedge clock);
      csr_addr  <= tfis_pkg::CSR_START_MINUTE;
      csr_wdata <= {10'd0, mn};
      @(posedge clock);
      csr_addr  <= tfis_pkg::CSR_SECTOR_SECONDS;
      csr_wdata <= secs;
      @(posedge clock);
      csr_addr  <= tfis_pkg::CSR_WEEKDAY_MASK;
      csr_wdata <= {9'd0, mask};
      @(posedge clock);
      csr_we    <= 1'b0;
      cfg = '{hr, mn, secs, mask};
   endtask

   task automatic note_error(input string msg);
      if (err_cnt < 10) $display("%s", msg);
      err_cnt++;
   endtask

   // Compare one result with the oldest pending expectation
   task automatic check_drive(input tfis_pkg::result_type got);
      tfis_pkg::result_type want;
      if (expected_drives.size() == 0) begin
         note_error($sformatf("unexpected result %h at %0t", got, $realtime));
         return;
      end
      want = expected_drives.pop_front();
      if (got.pump_on !== want.pump_on || got.tank_valve_on !== want.tank_valve_on ||
          got.sector_one_on !== want.sector_one_on ||
          got.sector_two_on !== want.sector_two_on || got.mode_now !== want.mode_now)
         note_error($sformatf(
            "mismatch at %0t: pump/tank/s1/s2/mode exp %b/%b/%b/%b/%0d got %b/%b/%b/%b/%0d",
            $realtime, want.pump_on, want.tank_valve_on, want.sector_one_on,
            want.sector_two_on, want.mode_now, got.pump_on, got.tank_valve_on,
            got.sector_one_on, got.sector_two_on, got.mode_now));
   endtask

   // Result side: check, then random stalls plus one long hold-off
   always @(posedge clock) begin
      int unsigned g;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_drive(tfis_pkg::result_type'(rsp_tdata[6:0]));
            drives_seen <= drives_seen + 1;
         end
         if (!long_hold_done && drives_seen >= HOLD_AT) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            rsp_tready     <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            g = pick_gap(rx_burst);
            if (g == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               hold_left  <= g - 1;
            end
         end
      end
   end

   // Watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Stimulus: directed table, then random phases under varied settings
   initial begin
      tfis_pkg::item_type it;
      logic [4:0]  hr;
      logic [5:0]  mn;
      logic [15:0] secs;
      logic [6:0]  mask;
      int unsigned n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_regs(5'd0, 6'd0, 16'd2, 7'h7F);
      foreach (dir_table[i]) begin
         it = '0;
         it.low_level   = dir_table[i].lo;
         it.high_level  = dir_table[i].hi;
         it.menu_key    = dir_table[i].mk;
         it.return_key  = dir_table[i].rk;
         it.hour_now    = dir_table[i].hr;
         it.minute_now  = dir_table[i].mn;
         it.weekday_now = dir_table[i].wd;
         push_item(it, dir_table[i].typed,
                   tfis_pkg::result_type'({dir_table[i].mode, dir_table[i].relays}));
      end
      settle();

      for (int p = 0; p < NUM_PHASES; p++) begin
         hr   = 5'($urandom_range(0, 23));
         mn   = 6'($urandom_range(0, 59));
         secs = 16'($urandom_range(1, 12));
         mask = 7'($urandom_range(0, 127));
         n    = 200;
         case (p)
            // zero duration: runs end on their first tick
            0: begin hr = 5'd23; mn = 6'd59; secs = 16'd0; mask = 7'h7F; n = 160; end
            // longest duration, the next phase cuts the run short
            1: begin hr = 5'd0; mn = 6'd0; secs = 16'hFFFF; mask = 7'h01; n = 80; end
            2: begin hr = 5'd12; mn = 6'd30; secs = 16'd1; mask = 7'h40; n = 160; end
            // reset defaults
            3: begin hr = 5'd10; mn = 6'd31; secs = 16'd60; mask = 7'h7F; n = 250; end
            // no weekday enabled
            4: begin hr = 5'd0; mn = 6'd59; secs = 16'd3; mask = 7'h00; n = 150; end
            7: begin hr = 5'd23; mn = 6'd0; secs = 16'd5; mask = 7'h2A; n = 180; end
            default: ;
         endcase
         program_regs(hr, mn, secs, mask);
         repeat (n) push_item(rand_item(), 1'b0, '0);
         settle();
      end

      if (err_cnt == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tfis_pkg.sv
hw/rtl/tfis_step.sv
hw/rtl/tank_fill_and_irrigation_sequencer_core.sv
hw/rtl/tfis_checker.sv
verif/tb.sv
